// File: rtl/crl_pkg.sv
`default_nettype none

package crl_pkg;

    // width of one parsed number
    localparam int VALUE_BITS = 32;
    // width of the queried cpu register
    localparam int CFG_W = 32;
    // common width for comparing numbers against the queried cpu
    localparam int CMP_W = (VALUE_BITS > CFG_W) ? VALUE_BITS : CFG_W;
    // accumulator width with room for the times-ten step
    localparam int PROD_W = VALUE_BITS + 4;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_NL    = 8'h0a;

    typedef enum logic [1:0] {
        PH_RANGE_FIRST,
        PH_IN_START,
        PH_END_FIRST,
        PH_IN_END
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic contains;
        logic malformed;
    } t_out_word;

    // parser state as it stands after the final byte of a list
    typedef struct packed {
        t_phase                  phase;
        logic [VALUE_BITS-1:0]   acc;
        logic [VALUE_BITS-1:0]   range_start;
        logic [VALUE_BITS-1:0]   prev_end;
        logic                    have_prev;
        logic                    found;
        logic                    error;
    } t_snap;

    typedef struct packed {
        logic                  bad;
        logic                  hit;
        logic [VALUE_BITS-1:0] hi;
    } t_close;

    // closes the range in progress: grammar, order and membership checks
    function automatic t_close close_range(
        input t_phase                phase,
        input logic [VALUE_BITS-1:0] acc,
        input logic [VALUE_BITS-1:0] range_start,
        input logic [VALUE_BITS-1:0] prev_end,
        input logic                  have_prev,
        input logic [CFG_W-1:0]      q
    );
        t_close                r;
        logic [VALUE_BITS-1:0] lo;
        logic [CMP_W-1:0]      lo_x;
        logic [CMP_W-1:0]      hi_x;
        logic [CMP_W-1:0]      q_x;
        lo   = (phase == PH_IN_END) ? range_start : acc;
        lo_x = CMP_W'(lo);
        hi_x = CMP_W'(acc);
        q_x  = CMP_W'(q);
        r.hi  = acc;
        r.bad = !(phase == PH_IN_START || phase == PH_IN_END)
                || (acc < lo)
                || (have_prev && (lo <= prev_end));
        r.hit = (q_x >= lo_x) && (q_x <= hi_x);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crl_byte_stage.sv
`default_nettype none

module crl_byte_stage (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire crl_pkg::t_in_word     i_word,
    input  wire logic [crl_pkg::CFG_W-1:0] i_queried_cpu,
    output logic                       o_snap_valid,
    input  wire logic                  i_snap_ready,
    output crl_pkg::t_snap             o_snap
);
    import crl_pkg::*;

    t_phase                r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_start, n_start;
    logic [VALUE_BITS-1:0] r_prev, n_prev;
    logic                  r_have_prev, n_have_prev;
    logic                  r_found, n_found;
    logic                  r_err, n_err;
    logic                  r_snap_vld;
    t_snap                 r_snap;

    logic                  accept;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [PROD_W-1:0]     acc_x;
    logic [PROD_W-1:0]     prod;
    logic                  ovf;
    t_close                cl;

    assign o_ready      = !r_snap_vld || i_snap_ready;
    assign accept       = i_valid && o_ready;
    assign o_snap_valid = r_snap_vld;
    assign o_snap       = r_snap;

    assign is_digit = (i_word.char_code >= CH_0) && (i_word.char_code <= CH_9);
    assign digit    = 4'(i_word.char_code - CH_0);

    // acc * 10 + d as two shifted adds, carry-out bits flag overflow
    assign acc_x = PROD_W'(r_acc);
    assign prod  = (acc_x << 3) + (acc_x << 1) + PROD_W'(digit);
    assign ovf   = |prod[PROD_W-1:VALUE_BITS];

    assign cl = close_range(r_phase, r_acc, r_start, r_prev, r_have_prev, i_queried_cpu);

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_start     = r_start;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_found     = r_found;
        n_err       = r_err;
        if (!r_err) begin
            if (is_digit) begin
                case (r_phase)
                    PH_RANGE_FIRST: begin
                        n_acc   = VALUE_BITS'(digit);
                        n_phase = PH_IN_START;
                    end
                    PH_END_FIRST: begin
                        n_acc   = VALUE_BITS'(digit);
                        n_phase = PH_IN_END;
                    end
                    default: begin
                        if (ovf) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc = prod[VALUE_BITS-1:0];
                        end
                    end
                endcase
            end else if (i_word.char_code == CH_DASH) begin
                if (r_phase == PH_IN_START) begin
                    n_start = r_acc;
                    n_acc   = '0;
                    n_phase = PH_END_FIRST;
                end else begin
                    n_err = 1'b1;
                end
            end else if (i_word.char_code == CH_COMMA) begin
                if (cl.bad) begin
                    n_err = 1'b1;
                end else begin
                    n_have_prev = 1'b1;
                    n_prev      = cl.hi;
                    n_found     = r_found || cl.hit;
                end
                n_acc   = '0;
                n_phase = PH_RANGE_FIRST;
            end else if (i_word.char_code == CH_NL && i_word.is_last) begin
                // end of text, final range is closed downstream
            end else begin
                n_err = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RANGE_FIRST;
            r_acc       <= '0;
            r_start     <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_found     <= 1'b0;
            r_err       <= 1'b0;
            r_snap_vld  <= 1'b0;
        end else begin
            if (accept && i_word.is_last) begin
                r_snap_vld <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_vld <= 1'b0;
            end
            if (accept) begin
                if (i_word.is_last) begin
                    r_phase     <= PH_RANGE_FIRST;
                    r_acc       <= '0;
                    r_start     <= '0;
                    r_prev      <= '0;
                    r_have_prev <= 1'b0;
                    r_found     <= 1'b0;
                    r_err       <= 1'b0;
                end else begin
                    r_phase     <= n_phase;
                    r_acc       <= n_acc;
                    r_start     <= n_start;
                    r_prev      <= n_prev;
                    r_have_prev <= n_have_prev;
                    r_found     <= n_found;
                    r_err       <= n_err;
                end
            end
        end
    end

    // snapshot payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && i_word.is_last) begin
            r_snap.phase       <= n_phase;
            r_snap.acc         <= n_acc;
            r_snap.range_start <= n_start;
            r_snap.prev_end    <= n_prev;
            r_snap.have_prev   <= n_have_prev;
            r_snap.found       <= n_found;
            r_snap.error       <= n_err;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_word.is_last) |=>
            (r_phase == PH_RANGE_FIRST && !r_err && !r_have_prev && !r_found))
        else $error("list state not cleared after last word");

    a_snap_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_vld && !i_snap_ready) |=> (r_snap_vld && $stable(r_snap)))
        else $error("pending list end lost");

    a_dash_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_END_FIRST) |-> (r_acc == '0))
        else $error("accumulator not cleared after dash");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(accept && i_word.is_last)) |=> r_err)
        else $error("error flag dropped inside a list");

endmodule

`default_nettype wire

// File: rtl/crl_close_stage.sv
`default_nettype none

module crl_close_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_snap_valid,
    output logic                           o_snap_ready,
    input  wire crl_pkg::t_snap            i_snap,
    input  wire logic [crl_pkg::CFG_W-1:0] i_queried_cpu,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output crl_pkg::t_out_word             o_word
);
    import crl_pkg::*;

    logic      r_out_vld;
    t_out_word r_out;
    t_out_word n_out;
    t_close    cl;
    logic      err;
    logic      found;
    logic      take;

    assign o_snap_ready = !r_out_vld || i_ready;
    assign take         = i_snap_valid && o_snap_ready;
    assign o_valid      = r_out_vld;
    assign o_word       = r_out;

    assign cl = close_range(i_snap.phase, i_snap.acc, i_snap.range_start,
                            i_snap.prev_end, i_snap.have_prev, i_queried_cpu);

    always_comb begin
        err             = i_snap.error || cl.bad;
        found           = i_snap.found || cl.hit;
        n_out.malformed = err;
        n_out.contains  = found && !err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.contains && r_out.malformed))
        else $error("contains set on a malformed list");

    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_vld)
        else $error("closed list did not reach the result register");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result word changed or dropped");

endmodule

`default_nettype wire

// File: rtl/cpu_range_list_membership_parser.sv
`default_nettype none

// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_in_word  (char_code, is_last)
// out       output     o_out_valid / i_out_ready    o_out_word (contains, malformed)
// cfg       input      i_cfg_we, no wait            i_cfg_wdata (queried cpu)
//
// one word accepted per cycle unless input is blocked; parse state updates in that cycle
// a last word gives its result through the list end register and then the result
// register; other words give no result
// the final range check (grammar, order, end not below start, membership) runs on the
// registered list end, so the digit accumulate never chains into the compares
// reset is synchronous, active low, and clears parse state, flags and the cpu number
// a stalled result blocks input only when a second list end is already waiting

module cpu_range_list_membership_parser (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire crl_pkg::t_in_word         i_in_word,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output crl_pkg::t_out_word             o_out_word,
    input  wire logic                      i_cfg_we,
    input  wire logic [crl_pkg::CFG_W-1:0] i_cfg_wdata
);
    import crl_pkg::*;

    // cpu number under test, kept across lists
    logic [CFG_W-1:0] r_queried_cpu;

    // list end handed from the byte parser to the closing stage
    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queried_cpu <= '0;
        end else if (i_cfg_we) begin
            r_queried_cpu <= i_cfg_wdata;
        end
    end

    // per-byte grammar, digit accumulate and comma range close
    crl_byte_stage u_byte (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_word        (i_in_word),
        .i_queried_cpu (r_queried_cpu),
        .o_snap_valid  (snap_valid),
        .i_snap_ready  (snap_ready),
        .o_snap        (snap)
    );

    // close of the last range and result register
    crl_close_stage u_close (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_snap_valid  (snap_valid),
        .o_snap_ready  (snap_ready),
        .i_snap        (snap),
        .i_queried_cpu (r_queried_cpu),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_word        (o_out_word)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import crl_pkg::*;

    // largest number a range may carry
    localparam longint unsigned NUM_MAX = (64'd1 << VALUE_BITS) - 64'd1;
    // carriage return, never legal in a list
    localparam logic [7:0] CH_CR = 8'h0d;
    // cycles without any accepted word before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    // length of the one long receiver hold-off
    localparam int LONG_HOLD = 60;

    // predicts the verdict of each list and holds the verdicts not yet returned
    class list_verdict_board;
        t_phase          ph;
        longint unsigned num;
        longint unsigned lo_num;
        longint unsigned last_hi;
        bit              seen;
        bit              hit;
        bit              broken;
        logic [CFG_W-1:0] cpu;
        t_out_word       pending[$];
        int              errors;

        function new();
            cpu    = '0;
            errors = 0;
            clear_list();
        endfunction

        function void clear_list();
            ph      = PH_RANGE_FIRST;
            num     = 0;
            lo_num  = 0;
            last_hi = 0;
            seen    = 0;
            hit     = 0;
            broken  = 0;
        endfunction

        // ends the range in progress at a comma or at the end of the list
        function void close_span();
            longint unsigned lo;
            if (ph == PH_IN_START) begin
                lo = num;
            end else if (ph == PH_IN_END) begin
                lo = lo_num;
            end else begin
                broken = 1;
                return;
            end
            if (num < lo || (seen && lo <= last_hi)) begin
                broken = 1;
                return;
            end
            seen    = 1;
            last_hi = num;
            if (cpu >= lo && cpu <= num) hit = 1;
        endfunction

        function void note_byte(t_in_word w);
            longint unsigned d;
            t_out_word       v;
            if (!broken) begin
                if (w.char_code >= CH_0 && w.char_code <= CH_9) begin
                    d = w.char_code - CH_0;
                    if (ph == PH_RANGE_FIRST) begin
                        num = d;
                        ph  = PH_IN_START;
                    end else if (ph == PH_END_FIRST) begin
                        num = d;
                        ph  = PH_IN_END;
                    end else if (num > (NUM_MAX - d) / 10) begin
                        broken = 1;
                    end else begin
                        num = num * 10 + d;
                    end
                end else if (w.char_code == CH_DASH) begin
                    if (ph == PH_IN_START) begin
                        lo_num = num;
                        num    = 0;
                        ph     = PH_END_FIRST;
                    end else begin
                        broken = 1;
                    end
                end else if (w.char_code == CH_COMMA) begin
                    close_span();
                    num = 0;
                    ph  = PH_RANGE_FIRST;
                end else if (!(w.char_code == CH_NL && w.is_last)) begin
                    broken = 1;
                end
            end
            if (w.is_last) begin
                if (!broken) close_span();
                v.contains  = hit && !broken;
                v.malformed = broken;
                pending.push_back(v);
                clear_list();
            end
        endfunction

        function void check_verdict(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                $error("verdict with no list end pending: contains=%0b malformed=%0b",
                       got.contains, got.malformed);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.contains !== want.contains) begin
                $error("contains: expected %0b, got %0b", want.contains, got.contains);
                errors++;
            end
            if (got.malformed !== want.malformed) begin
                $error("malformed: expected %0b, got %0b", want.malformed, got.malformed);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_word         in_word = '0;
    logic             out_valid;
    logic             out_ready = 1'b1;
    t_out_word        out_word;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // random idle bursts on both sides while set
    logic idle_on = 1'b1;
    // asks the receiver for its one long hold-off
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   stall_left = 0;
    int   quiet = 0;
    int   sent_bytes = 0;

    // bytes of the list being built
    logic [7:0] text_q[$];

    list_verdict_board board;

    always #1 clk = ~clk;

    cpu_range_list_membership_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // receiver: short random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done  <= 1'b1;
            stall_left <= LONG_HOLD;
            out_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 2);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: every accepted word goes to the board, every taken verdict is checked
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) board.note_byte(in_word);
            if (out_valid && out_ready) board.check_verdict(out_word);
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // offers one word and returns at the edge that takes it
    task automatic send_word(input logic [7:0] c, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_word.char_code <= c;
        in_word.is_last   <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // sends the built list, its final byte marked last
    task automatic send_text_q();
        foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
        sent_bytes += text_q.size();
        text_q.delete();
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // decimal text of v, now and then with leading zeros
    function automatic void add_number(longint unsigned v);
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(CH_0);
        end
        add_str($sformatf("%0d", v));
    endfunction

    // stop offering, wait for every verdict, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_cpu(input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        board.cpu = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random lists until about n_bytes more bytes have gone in
    task automatic run_lists(input int n_bytes);
        int              stop_at;
        int              kind;
        int              n;
        int              pos;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned nxt;
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                // ascending ranges, either near zero or near the top of the value range
                nxt = ($urandom_range(0, 4) == 0) ? NUM_MAX - $urandom_range(0, 40)
                                                  : $urandom_range(0, 4);
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    lo = nxt;
                    hi = lo + ($urandom_range(0, 1) ? $urandom_range(0, 6) : 0);
                    if (hi > NUM_MAX) hi = NUM_MAX;
                    if (i != 0) text_q.push_back(CH_COMMA);
                    add_number(lo);
                    if (hi != lo || $urandom_range(0, 5) == 0) begin
                        text_q.push_back(CH_DASH);
                        add_number(hi);
                    end
                    if (hi + 5 > NUM_MAX) break;
                    nxt = hi + 1 + $urandom_range(0, 4);
                end
                if ($urandom_range(0, 1)) text_q.push_back(CH_NL);
                // some lists get one byte spoiled
                if (kind >= 11) begin
                    pos = $urandom_range(0, text_q.size() - 1);
                    case ($urandom_range(0, 4))
                        0: text_q[pos] = 8'($urandom_range(0, 255));
                        1: text_q.insert(pos, CH_COMMA);
                        2: text_q.insert(pos, CH_DASH);
                        3: text_q.insert(pos, $urandom_range(0, 1) ? CH_NL : CH_CR);
                        default: text_q.push_back(CH_COMMA);
                    endcase
                end
            end else if (kind < 16) begin
                lo = $urandom_range(1, 20);
                hi = lo + $urandom_range(0, 5);
                if (kind == 14) begin
                    // next range starts at or below the previous end
                    add_number(lo);
                    text_q.push_back(CH_DASH);
                    add_number(hi);
                    text_q.push_back(CH_COMMA);
                    add_number($urandom_range(0, int'(hi)));
                end else begin
                    // end below start
                    add_number(hi);
                    text_q.push_back(CH_DASH);
                    add_number(hi - $urandom_range(1, int'(hi)));
                end
            end else if (kind < 18) begin
                // around the overflow boundary, sometimes far past it
                if ($urandom_range(0, 1)) add_str("1,");
                if ($urandom_range(0, 3) == 0) begin
                    add_number(NUM_MAX * $urandom_range(2, 20));
                end else begin
                    add_number(NUM_MAX - 1 + $urandom_range(0, 3));
                end
            end else begin
                // noise, half of it digits
                repeat ($urandom_range(1, 6)) begin
                    text_q.push_back($urandom_range(0, 1) ? 8'(CH_0 + $urandom_range(0, 9))
                                                          : 8'($urandom_range(0, 255)));
                end
            end
            send_text_q();
        end
    endtask

    initial begin
        logic [CFG_W-1:0] cpu_pick[6];
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lists with the queried cpu still at its reset value
        add_str("\n");                  // nothing but the newline
        send_text_q();
        text_q.push_back(CH_CR);        // carriage return
        send_text_q();
        add_str(",");                   // empty range
        send_text_q();
        add_str("7-");                  // dash with no end
        send_text_q();
        add_str("2--");                 // second dash
        send_text_q();
        add_str("1,,2");                // doubled comma
        send_text_q();
        add_str("3,");                  // trailing comma
        send_text_q();
        add_str("\n1");                 // newline before the last byte
        send_text_q();
        add_str("0-3,8\n");             // well formed, hits cpu 0
        send_text_q();
        text_q.push_back(8'hff);        // all-ones byte
        send_text_q();
        text_q.push_back(8'h00);        // all-zeros byte
        send_text_q();
        drain();

        // random phases, one queried cpu each, extremes included
        cpu_pick = '{32'hffff_ffff, 32'd0, 32'd7, 32'($urandom_range(0, 40)),
                     32'hffff_fffe, 32'($urandom)};
        foreach (cpu_pick[k]) begin
            program_cpu(cpu_pick[k]);
            idle_on <= ($urandom_range(0, 3) != 0);
            run_lists(190);
            drain();
        end

        // receiver holds off for a long stretch while short lists keep coming
        program_cpu(32'd5);
        idle_on  <= 1'b0;
        hold_req <= 1'b1;
        repeat (24) begin
            text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
            text_q.push_back(CH_NL);
            send_text_q();
        end
        drain();

        // closing stretch at full rate, no idling
        program_cpu(32'($urandom_range(0, 12)));
        run_lists(120);
        drain();

        if (board.pending.size() != 0) begin
            $error("%0d verdicts never arrived", board.pending.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/crl_pkg.sv
rtl/crl_byte_stage.sv
rtl/crl_close_stage.sv
rtl/cpu_range_list_membership_parser.sv
verif/testbench.sv
